@@ src/lcdw_pkg.sv @@
package lcdw_pkg;

    // Screen geometry: cells at or past this index sit on the second line.
    localparam int LINE_LENGTH = 16;

    // Command codes of an input transaction.
    localparam logic [2:0] CMD_COMMAND   = 3'd0;
    localparam logic [2:0] CMD_CHAR      = 3'd1;
    localparam logic [2:0] CMD_PLACE_CHR = 3'd2;
    localparam logic [2:0] CMD_PLACE_CUR = 3'd3;
    localparam logic [2:0] CMD_PLACE_DEC = 3'd4;
    localparam logic [2:0] CMD_BACKLIGHT = 3'd5;
    localparam logic [2:0] CMD_INIT      = 3'd6;

    // Instruction and character bytes.
    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
    localparam logic [6:0] LINE2_BASE     = 7'h40;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] FUNC_SET_4BIT  = 8'h28;
    localparam logic [7:0] CLEAR_DISPLAY  = 8'h01;
    localparam logic [7:0] ENTRY_MODE     = 8'h06;
    localparam logic [7:0] DISPLAY_ON     = 8'h0C;

    // Wake-up nibbles sent before the busy flag can be read.
    localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB   = 4'h2;
    localparam logic [1:0] WAKE_COUNT     = 2'd3;

    // Queue between the decoder and the sequencer.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] position;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       strobe_res;
        logic       backlight;
        logic       wait_ready;
        logic       last;
    } t_out_item;

    // One decoded transaction: up to four bytes, an optional wake-up
    // prefix, or a backlight level change.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [3:0]      rs;
        logic [1:0]      last_idx;
        logic            init;
        logic            bl;
        logic            bl_on;
    } t_desc;

endpackage

@@ src/lcdw_front.sv @@
module lcdw_front (
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lcdw_pkg::t_in_item i_in_data,
    input  logic             i_full,
    output logic             o_push,
    output lcdw_pkg::t_desc  o_desc
);
    import lcdw_pkg::*;

    logic [13:0] h_prod;
    logic [1:0]  hundreds;
    logic [7:0]  h_scaled;
    logic [6:0]  rem;
    logic [14:0] t_prod;
    logic [3:0]  tens;
    logic [7:0]  t_scaled;
    logic [3:0]  ones;
    logic [6:0]  addr;
    logic [7:0]  addr_byte;
    logic [7:0]  dig_h;
    logic [7:0]  dig_t;
    logic [7:0]  dig_o;
    logic        known;

    // Decimal digits by reciprocal multiplication; exact for 8-bit values.
    always_comb begin
        h_prod   = 14'(i_in_data.value) * 14'd41;
        hundreds = h_prod[13:12];
        h_scaled = 8'(hundreds) * 8'd100;
        rem      = 7'(i_in_data.value - h_scaled);
        t_prod   = 15'(rem) * 15'd205;
        tens     = t_prod[14:11];
        t_scaled = 8'(tens) * 8'd10;
        ones     = 4'(8'(rem) - t_scaled);
        dig_h    = ASCII_ZERO | 8'(hundreds);
        dig_t    = ASCII_ZERO | 8'(tens);
        dig_o    = ASCII_ZERO | 8'(ones);
    end

    // Cells past the first line map onto the second line's addresses.
    always_comb begin
        if (7'(i_in_data.position) >= 7'(LINE_LENGTH)) begin
            addr = LINE2_BASE + 7'(i_in_data.position) - 7'(LINE_LENGTH);
        end else begin
            addr = 7'(i_in_data.position);
        end
        addr_byte = SET_DDRAM_ADDR | 8'(addr);
    end

    // Classify the command into a byte list for the sequencer.
    always_comb begin
        o_desc = '0;
        known  = 1'b1;
        unique case (i_in_data.cmd)
            CMD_COMMAND: begin
                o_desc.bytes[0] = i_in_data.value;
            end
            CMD_CHAR: begin
                o_desc.bytes[0] = i_in_data.value;
                o_desc.rs[0]    = 1'b1;
            end
            CMD_PLACE_CHR: begin
                o_desc.bytes[0] = addr_byte;
                o_desc.bytes[1] = i_in_data.value;
                o_desc.rs[1]    = 1'b1;
                o_desc.last_idx = 2'd1;
            end
            CMD_PLACE_CUR: begin
                o_desc.bytes[0] = addr_byte;
            end
            CMD_PLACE_DEC: begin
                o_desc.bytes[0] = addr_byte;
                o_desc.rs       = 4'b1110;
                if (hundreds != 2'd0) begin
                    o_desc.bytes[1] = dig_h;
                    o_desc.bytes[2] = dig_t;
                    o_desc.bytes[3] = dig_o;
                    o_desc.last_idx = 2'd3;
                end else begin
                    o_desc.bytes[1] = dig_t;
                    o_desc.bytes[2] = dig_o;
                    o_desc.last_idx = 2'd2;
                end
            end
            CMD_BACKLIGHT: begin
                o_desc.bl    = 1'b1;
                o_desc.bl_on = (i_in_data.value != 8'd0);
            end
            CMD_INIT: begin
                o_desc.init     = 1'b1;
                o_desc.bytes[0] = FUNC_SET_4BIT;
                o_desc.bytes[1] = CLEAR_DISPLAY;
                o_desc.bytes[2] = ENTRY_MODE;
                o_desc.bytes[3] = DISPLAY_ON;
                o_desc.last_idx = 2'd3;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unused codes are taken and dropped.
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full && known;

endmodule

@@ src/lcdw_fifo.sv @@
module lcdw_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcdw_pkg::t_desc i_wdata,
    input  logic            i_pop,
    output lcdw_pkg::t_desc o_rdata,
    output logic            o_empty,
    output logic            o_full
);
    import lcdw_pkg::*;

    t_desc              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));

endmodule

@@ src/lcdw_back.sv @@
module lcdw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcdw_pkg::t_desc    i_desc,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lcdw_pkg::t_out_item o_out_data
);
    import lcdw_pkg::*;

    t_desc     r_desc;
    logic      r_busy;
    logic [1:0] r_pre_cnt;
    logic [1:0] r_idx;
    logic      r_half;
    logic      r_light;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      emit;
    t_out_item cur;
    logic [7:0] cur_byte;

    // Current transfer from the sequencer position.
    always_comb begin
        cur_byte       = r_desc.bytes[r_idx];
        cur            = '0;
        cur.backlight  = r_light;
        if (r_desc.bl) begin
            cur.backlight = r_desc.bl_on;
            cur.last      = 1'b1;
        end else if (r_pre_cnt != 2'd0) begin
            cur.nibble     = (r_pre_cnt == 2'd1) ? FOUR_BIT_NIB : WAKE_NIBBLE;
            cur.strobe_res = 1'b1;
        end else begin
            cur.rs         = r_desc.rs[r_idx];
            cur.nibble     = r_half ? cur_byte[3:0] : cur_byte[7:4];
            cur.strobe_res = 1'b1;
            cur.wait_ready = r_half;
            cur.last       = r_half && (r_idx == r_desc.last_idx);
        end
    end

    assign emit  = r_busy && (!r_out_valid || i_out_ready);
    assign o_pop = !i_empty && (!r_busy || (emit && cur.last));

    // Sequencer: one transfer per cycle while the output slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pre_cnt <= 2'd0;
            r_idx     <= 2'd0;
            r_half    <= 1'b0;
        end else if (o_pop) begin
            r_busy    <= 1'b1;
            r_pre_cnt <= i_desc.init ? WAKE_COUNT : 2'd0;
            r_idx     <= 2'd0;
            r_half    <= 1'b0;
        end else if (emit) begin
            if (cur.last) begin
                r_busy <= 1'b0;
            end else if (r_pre_cnt != 2'd0) begin
                r_pre_cnt <= r_pre_cnt - 1'b1;
            end else if (r_half) begin
                r_idx  <= r_idx + 1'b1;
                r_half <= 1'b0;
            end else begin
                r_half <= 1'b1;
            end
        end
    end

    // Descriptor of the transaction in progress.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
    end

    // Backlight level follows the most recent backlight transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= 1'b0;
        end else if (emit && r_desc.bl) begin
            r_light <= r_desc.bl_on;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= cur;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/char_lcd_nibble_writer.sv @@
// Host side of a 4-bit character LCD link. Each input transaction is one
// command (raw instruction, character, placed character, cursor placement,
// placed decimal byte, backlight level or power-up sequence) and yields one
// result per nibble transfer: the high nibble then the low nibble of each
// byte, with wait_ready set on the low nibble and last on the final result.
// A decoder classifies the command into a byte list and pushes it into a
// two-entry queue; a sequencer plays it out one result per cycle into an
// output register while that register is free. A transaction yields 2
// results for a command or character, 4 for a placed character, 6 or 8 for
// a decimal byte, 1 for backlight and 11 for the power-up sequence, with
// consecutive transactions streaming back to back.
// Command code 7 is accepted and produces nothing.
module char_lcd_nibble_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lcdw_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lcdw_pkg::t_out_item o_out_data
);
    import lcdw_pkg::*;

    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;
    t_desc wr_desc;
    t_desc rd_desc;

    lcdw_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_push     (push),
        .o_desc     (wr_desc)
    );

    lcdw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_desc),
        .i_pop   (pop),
        .o_rdata (rd_desc),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    lcdw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (rd_desc),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ bench/tb_char_lcd_nibble_writer.sv @@
module tb_char_lcd_nibble_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdw_pkg::*;

    // Code that the block accepts and ignores.
    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam logic       RS_INSTR     = 1'b0;
    localparam logic       RS_DATA      = 1'b1;
    localparam int         RANDOM_ITEMS = 450;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         PRINT_LIMIT  = 30;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_pending_cmd;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    t_pending_cmd pending_commands[$];
    t_out_item    expected_transfers[$];
    bit           light_level = 1'b0;
    bit           results_drained = 1'b1;
    bit           sender_calm = 1'b0;
    bit           receiver_calm = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           error_count = 0;
    int           transfer_count = 0;
    int           cycle_count = 0;

    char_lcd_nibble_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Clock and a single reset pulse at the start of the run.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Count mismatches and print only the first few of them.
    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("ERROR at transfer %0d: %s", transfer_count, what);
        end
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want) begin
            flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Expected transfer builders; the backlight level is the current one.
    task automatic push_nibble(input logic rs, input logic [3:0] nib,
                               input logic strobe, input logic wait_rdy);
        t_out_item t;
        t.rs         = rs;
        t.nibble     = nib;
        t.strobe_res = strobe;
        t.backlight  = light_level;
        t.wait_ready = wait_rdy;
        t.last       = 1'b0;
        expected_transfers.push_back(t);
    endtask

    task automatic push_byte(input logic rs, input logic [7:0] code);
        push_nibble(rs, code[7:4], 1'b1, 1'b0);
        push_nibble(rs, code[3:0], 1'b1, 1'b1);
    endtask

    // Cells past the first line land on the second line's DDRAM range.
    task automatic push_address(input logic [4:0] pos);
        logic [7:0] addr;
        if (pos >= LINE_LENGTH) begin
            addr = {1'b0, LINE2_BASE} + 8'(pos - LINE_LENGTH);
        end else begin
            addr = {3'b000, pos};
        end
        push_byte(RS_INSTR, SET_DDRAM_ADDR | addr);
    endtask

    // Expand one accepted command into the nibble transfers it must produce.
    task automatic predict_transfers(input t_in_item item);
        int queued;
        int hundreds;
        int tens;
        int ones;
        queued   = expected_transfers.size();
        hundreds = item.value / 100;
        tens     = (item.value % 100) / 10;
        ones     = item.value % 10;
        case (item.cmd)
            CMD_COMMAND: begin
                push_byte(RS_INSTR, item.value);
            end
            CMD_CHAR: begin
                push_byte(RS_DATA, item.value);
            end
            CMD_PLACE_CHR: begin
                push_address(item.position);
                push_byte(RS_DATA, item.value);
            end
            CMD_PLACE_CUR: begin
                push_address(item.position);
            end
            CMD_PLACE_DEC: begin
                push_address(item.position);
                if (hundreds != 0) begin
                    push_byte(RS_DATA, ASCII_ZERO | 8'(hundreds));
                end
                push_byte(RS_DATA, ASCII_ZERO | 8'(tens));
                push_byte(RS_DATA, ASCII_ZERO | 8'(ones));
            end
            CMD_BACKLIGHT: begin
                light_level = (item.value != 8'd0);
                push_nibble(RS_INSTR, 4'h0, 1'b0, 1'b0);
            end
            CMD_INIT: begin
                push_nibble(RS_INSTR, WAKE_NIBBLE, 1'b1, 1'b0);
                push_nibble(RS_INSTR, WAKE_NIBBLE, 1'b1, 1'b0);
                push_nibble(RS_INSTR, FOUR_BIT_NIB, 1'b1, 1'b0);
                push_byte(RS_INSTR, FUNC_SET_4BIT);
                push_byte(RS_INSTR, CLEAR_DISPLAY);
                push_byte(RS_INSTR, ENTRY_MODE);
                push_byte(RS_INSTR, DISPLAY_ON);
            end
            default: begin
            end
        endcase
        if (expected_transfers.size() > queued) begin
            expected_transfers[expected_transfers.size() - 1].last = 1'b1;
        end
    endtask

    task automatic queue_command(input logic [2:0] cmd, input logic [4:0] pos,
                                 input logic [7:0] value, input bit drain);
        t_pending_cmd p;
        p.item.cmd      = cmd;
        p.item.position = pos;
        p.item.value    = value;
        p.drain         = drain;
        pending_commands.push_back(p);
    endtask

    // Driver: presents pending commands with random gaps between them.
    always @(posedge i_clk) begin
        logic accepted;
        logic next_valid;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            accepted   = in_valid && in_ready;
            next_valid = in_valid && !accepted;
            if (accepted) begin
                send_gap = pick_gap(sender_calm);
            end
            if ($urandom_range(0, 199) == 0) begin
                sender_calm = !sender_calm;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_commands.size() > 0 &&
                             !(pending_commands[0].drain &&
                               (accepted || !results_drained))) begin
                    in_data <= pending_commands[0].item;
                    pending_commands.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Receiver: random stalls on the result channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) begin
                receiver_calm = !receiver_calm;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_left = pick_gap(receiver_calm);
            end
        end
    end

    // Monitor: predicts on each input transaction, checks each result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                predict_transfers(in_data);
            end
            if (out_valid && out_ready) begin
                if (expected_transfers.size() == 0) begin
                    flag_error("result transaction with nothing expected");
                end else begin
                    want = expected_transfers.pop_front();
                    compare_field("rs", out_data.rs, want.rs);
                    compare_field("nibble", out_data.nibble, want.nibble);
                    compare_field("strobe_res", out_data.strobe_res, want.strobe_res);
                    compare_field("backlight", out_data.backlight, want.backlight);
                    compare_field("wait_ready", out_data.wait_ready, want.wait_ready);
                    compare_field("last", out_data.last, want.last);
                end
                transfer_count++;
            end
        end
        results_drained <= (expected_transfers.size() == 0);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus: a directed opening, then random commands.
    initial begin
        int count;
        int r;
        logic [2:0] cmd;
        logic [7:0] value;

        // Power-up with the backlight off and on, then byte extremes.
        queue_command(CMD_INIT, 5'd0, 8'h00, 1'b0);
        queue_command(CMD_BACKLIGHT, 5'd0, 8'h01, 1'b0);
        queue_command(CMD_INIT, 5'd31, 8'hFF, 1'b0);
        queue_command(CMD_COMMAND, 5'd0, 8'h00, 1'b0);
        queue_command(CMD_COMMAND, 5'd31, 8'hFF, 1'b0);
        queue_command(CMD_CHAR, 5'd0, 8'h41, 1'b0);
        queue_command(CMD_CHAR, 5'd31, 8'hFF, 1'b0);
        // Line boundaries for placed characters and the cursor.
        queue_command(CMD_PLACE_CHR, 5'd0, 8'h5A, 1'b0);
        queue_command(CMD_PLACE_CHR, 5'd15, 8'hA5, 1'b0);
        queue_command(CMD_PLACE_CHR, 5'd16, 8'h00, 1'b0);
        queue_command(CMD_PLACE_CHR, 5'd31, 8'hFF, 1'b0);
        queue_command(CMD_PLACE_CUR, 5'd0, 8'h00, 1'b0);
        queue_command(CMD_PLACE_CUR, 5'd31, 8'h00, 1'b0);
        // Decimal printing with and without a hundreds digit.
        queue_command(CMD_PLACE_DEC, 5'd3, 8'd0, 1'b0);
        queue_command(CMD_PLACE_DEC, 5'd15, 8'd5, 1'b0);
        queue_command(CMD_PLACE_DEC, 5'd16, 8'd99, 1'b0);
        queue_command(CMD_PLACE_DEC, 5'd20, 8'd100, 1'b0);
        queue_command(CMD_PLACE_DEC, 5'd17, 8'd255, 1'b0);
        // The ignored code, then backlight with a non-unit value and off.
        queue_command(CMD_UNUSED, 5'd31, 8'hFF, 1'b0);
        queue_command(CMD_BACKLIGHT, 5'd9, 8'h80, 1'b0);
        queue_command(CMD_BACKLIGHT, 5'd0, 8'h00, 1'b1);
        queue_command(CMD_PLACE_DEC, 5'd16, 8'd10, 1'b0);
        queue_command(CMD_CHAR, 5'd0, 8'h7E, 1'b0);

        count = 0;
        while (count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            cmd = (r < 4) ? CMD_UNUSED : 3'($urandom_range(0, 6));
            value = 8'($urandom_range(0, 255));
            if (cmd == CMD_PLACE_DEC && $urandom_range(0, 9) < 4) begin
                value = 8'($urandom_range(0, 99));
            end else if (cmd == CMD_BACKLIGHT && $urandom_range(0, 1) == 0) begin
                value = 8'h00;
            end
            if (cmd != CMD_UNUSED) begin
                count++;
            end
            queue_command(cmd, 5'($urandom_range(0, 31)), value, (count % 120) == 0);
        end

        // Wait for all commands to go in and all transfers to come out.
        // Sampling on the falling edge sees the settled driver and monitor.
        while (pending_commands.size() > 0 || in_valid || expected_transfers.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_transfers.size() > 0) begin
            flag_error($sformatf("%0d expected transfers never arrived",
                                 expected_transfers.size()));
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ char_lcd_nibble_writer.f @@
src/lcdw_pkg.sv
src/lcdw_front.sv
src/lcdw_fifo.sv
src/lcdw_back.sv
src/char_lcd_nibble_writer.sv
bench/tb_char_lcd_nibble_writer.sv
